// ===== hdl/qsp_pkg.sv =====
// ---------------------------------------------------------------------------
// qsp_pkg : queue selection policy package
// widths, policy codes and sequencer state type shared by the scheduler
// ---------------------------------------------------------------------------
`default_nettype none

package qsp_pkg;

    // field widths
    localparam int TIME_W   = 32;
    localparam int LEN_W    = 16;
    localparam int WAIT_W   = 32;
    localparam int WPK_W    = 16;
    localparam int SUM_W    = 48;
    localparam int PROD_W   = LEN_W + TIME_W;
    localparam int CHOSEN_W = 4;

    // signed numerator and score, magnitude for the divider
    localparam int NUM_W    = 50;
    localparam int MAG_W    = NUM_W - 1;
    localparam int SCORE_W  = NUM_W;
    localparam int REM_W    = WPK_W + 1;

    // restoring divider, one quotient bit per cycle
    localparam int DIV_STEPS = MAG_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        POL_ROUND_ROBIN = 2'd0,
        POL_OLDEST_HEAD = 2'd1,
        POL_UTILITY     = 2'd2,
        POL_LARGEST     = 2'd3
    } policy_t;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_EVAL = 13'b0000000000010,
        S_MUL  = 13'b0000000000100,
        S_SUB  = 13'b0000000001000,
        S_ADD  = 13'b0000000010000,
        S_ABS  = 13'b0000000100000,
        S_DIV  = 13'b0000001000000,
        S_NEG  = 13'b0000010000000,
        S_CMP  = 13'b0000100000000,
        S_NEXT = 13'b0001000000000,
        S_MOD  = 13'b0010000000000,
        S_SRCH = 13'b0100000000000,
        S_OUT  = 13'b1000000000000
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/queue_selection_policy_top.sv =====
// ---------------------------------------------------------------------------
// queue_selection_policy_top : multi-policy queue scheduler
// picks the next queue to serve by round robin, oldest head, utility or
// largest queue, from one status transaction per queue
// ---------------------------------------------------------------------------
// usage
//   input: one transaction per queue, queue 0 first, taken when start is high
//     and busy is low; last_queue closes the selection
//   config: the user writes the policy over cfg_valid / cfg_ready / cfg_data
//     only while the block is idle; the block itself does not enforce this;
//     it is latched at the first transaction of a selection
//   output: result_valid strobes for one cycle with chosen_queue and found,
//     once per selection, in the cycle busy falls after the closing transaction
//   busy covers a transaction from acceptance to its last step; only one is
//     held at a time, so the next is taken after busy falls. Steps in order:
//     round robin, empty queue, one past the queue limit: evaluate, next
//     oldest head, largest queue, zero-window utility: evaluate, compare, next
//     other utility: evaluate, multiply, subtract, add, absolute value, divide
//     (restoring, one quotient bit per cycle, 49 bits), negate, compare, next
//   closing a selection adds the output step, and for round robin first a
//     repeated-subtraction modulo step and a one-queue-per-cycle search
//   reset clears the policy, the round robin pointer and the run state; the
//     receiver cannot stall, so no result is ever held back
// ---------------------------------------------------------------------------
`default_nettype none

module queue_selection_policy_top #(
    parameter int MAX_QUEUES = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    // input transaction
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [qsp_pkg::TIME_W-1:0]    current_time,
    input  wire logic [qsp_pkg::LEN_W-1:0]     queue_length,
    input  wire logic [qsp_pkg::WAIT_W-1:0]    head_wait,
    input  wire logic [qsp_pkg::WPK_W-1:0]     window_packets,
    input  wire logic [qsp_pkg::SUM_W-1:0]     window_arrival_sum,
    input  wire logic [qsp_pkg::SUM_W-1:0]     window_wait_sum,
    input  wire logic                          last_queue,

    // policy register write
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [1:0]                    cfg_data,

    // result
    output logic                               result_valid,
    output logic [qsp_pkg::CHOSEN_W-1:0]       chosen_queue,
    output logic                               found
);

    // index and count widths follow the queue limit
    localparam int IDX_W = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
    localparam int CNT_W = $clog2(MAX_QUEUES + 1);

    // control state
    qsp_pkg::state_t                 state_reg,        state_next;
    qsp_pkg::policy_t                policy_reg,       policy_next;
    qsp_pkg::policy_t                run_policy_reg,   run_policy_next;
    logic [IDX_W-1:0]                rr_pointer_reg,   rr_pointer_next;
    logic                            rr_valid_reg,     rr_valid_next;
    logic [MAX_QUEUES-1:0]           nonempty_reg,     nonempty_next;
    logic [qsp_pkg::SCORE_W-1:0]     best_score_reg,   best_score_next;
    logic [IDX_W-1:0]                best_index_reg,   best_index_next;
    logic                            best_found_reg,   best_found_next;
    logic [CNT_W-1:0]                item_count_reg,   item_count_next;
    logic                            result_valid_reg, result_valid_next;
    logic [qsp_pkg::CHOSEN_W-1:0]    chosen_reg,       chosen_next;
    logic                            found_reg,        found_next;

    // datapath registers
    logic [qsp_pkg::TIME_W-1:0]      now_reg,          now_next;
    logic [qsp_pkg::LEN_W-1:0]       len_reg,          len_next;
    logic [qsp_pkg::WAIT_W-1:0]      wait_reg,         wait_next;
    logic [qsp_pkg::WPK_W-1:0]       wpk_reg,          wpk_next;
    logic [qsp_pkg::SUM_W-1:0]       asum_reg,         asum_next;
    logic [qsp_pkg::SUM_W-1:0]       wsum_reg,         wsum_next;
    logic                            last_reg,         last_next;
    logic [qsp_pkg::PROD_W-1:0]      prod_reg,         prod_next;
    logic [qsp_pkg::NUM_W-1:0]       num_reg,          num_next;
    logic                            neg_reg,          neg_next;
    logic [qsp_pkg::MAG_W-1:0]       dvd_reg,          dvd_next;
    logic [qsp_pkg::REM_W-1:0]       rem_reg,          rem_next;
    logic [qsp_pkg::DIV_CNT_W-1:0]   div_cnt_reg,      div_cnt_next;
    logic [qsp_pkg::SCORE_W-1:0]     score_reg,        score_next;
    logic [CNT_W-1:0]                rr_rem_reg,       rr_rem_next;
    logic [IDX_W-1:0]                srch_idx_reg,     srch_idx_next;
    logic [CNT_W-1:0]                srch_k_reg,       srch_k_next;

    // helpers
    logic                            accept;
    logic                            in_range;
    logic [qsp_pkg::NUM_W-1:0]       num_abs;
    logic [qsp_pkg::REM_W-1:0]       rem_shift;
    logic [qsp_pkg::REM_W-1:0]       wpk_ext;
    logic                            q_bit;
    logic [qsp_pkg::SCORE_W-1:0]     quot_ext;
    logic [CNT_W-1:0]                cnt_m1;
    logic [CNT_W-1:0]                rr_inc;
    logic [CNT_W-1:0]                srch_inc;
    logic [CNT_W-1:0]                srch_k_inc;
    logic [IDX_W+qsp_pkg::CHOSEN_W-1:0] idx_ext;

    assign accept    = start && (state_reg == qsp_pkg::S_IDLE);
    assign busy      = (state_reg != qsp_pkg::S_IDLE);
    assign cfg_ready = 1'b1;

    assign result_valid = result_valid_reg;
    assign chosen_queue = chosen_reg;
    assign found        = found_reg;

    // items past the queue limit are skipped, but still close the run
    assign in_range = (item_count_reg < CNT_W'(MAX_QUEUES));

    // divider step and sign handling
    assign num_abs   = num_reg[qsp_pkg::NUM_W-1] ? (~num_reg + 1'b1) : num_reg;
    assign rem_shift = {rem_reg[qsp_pkg::REM_W-2:0], dvd_reg[qsp_pkg::MAG_W-1]};
    assign wpk_ext   = {1'b0, wpk_reg};
    assign q_bit     = (rem_shift >= wpk_ext);
    assign quot_ext  = {1'b0, dvd_reg};

    // round robin index arithmetic
    assign cnt_m1     = item_count_reg - 1'b1;
    assign rr_inc     = rr_rem_reg + 1'b1;
    assign srch_inc   = CNT_W'(srch_idx_reg) + 1'b1;
    assign srch_k_inc = srch_k_reg + 1'b1;

    assign idx_ext = {{qsp_pkg::CHOSEN_W{1'b0}}, best_index_reg};

    always_comb
    begin
        state_next        = state_reg;
        policy_next       = policy_reg;
        run_policy_next   = run_policy_reg;
        rr_pointer_next   = rr_pointer_reg;
        rr_valid_next     = rr_valid_reg;
        nonempty_next     = nonempty_reg;
        best_score_next   = best_score_reg;
        best_index_next   = best_index_reg;
        best_found_next   = best_found_reg;
        item_count_next   = item_count_reg;
        result_valid_next = 1'b0;
        chosen_next       = chosen_reg;
        found_next        = found_reg;

        now_next      = now_reg;
        len_next      = len_reg;
        wait_next     = wait_reg;
        wpk_next      = wpk_reg;
        asum_next     = asum_reg;
        wsum_next     = wsum_reg;
        last_next     = last_reg;
        prod_next     = prod_reg;
        num_next      = num_reg;
        neg_next      = neg_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        div_cnt_next  = div_cnt_reg;
        score_next    = score_reg;
        rr_rem_next   = rr_rem_reg;
        srch_idx_next = srch_idx_reg;
        srch_k_next   = srch_k_reg;

        // policy write transaction
        if (cfg_valid && cfg_ready)
        begin
            policy_next = qsp_pkg::policy_t'(cfg_data);
        end

        case (state_reg)
            qsp_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    now_next  = current_time;
                    len_next  = queue_length;
                    wait_next = head_wait;
                    wpk_next  = window_packets;
                    asum_next = window_arrival_sum;
                    wsum_next = window_wait_sum;
                    last_next = last_queue;
                    if (item_count_reg == '0)
                    begin
                        run_policy_next = policy_reg;
                    end
                    state_next = qsp_pkg::S_EVAL;
                end
            end

            qsp_pkg::S_EVAL:
            begin
                state_next = qsp_pkg::S_NEXT;
                if (in_range && (len_reg != '0))
                begin
                    nonempty_next = nonempty_reg
                                  | (MAX_QUEUES'(1) << item_count_reg[IDX_W-1:0]);
                    case (run_policy_reg)
                        qsp_pkg::POL_OLDEST_HEAD:
                        begin
                            score_next = {{(qsp_pkg::SCORE_W-qsp_pkg::WAIT_W){1'b0}},
                                          wait_reg};
                            state_next = qsp_pkg::S_CMP;
                        end
                        qsp_pkg::POL_UTILITY:
                        begin
                            if (wpk_reg != '0)
                            begin
                                state_next = qsp_pkg::S_MUL;
                            end
                            else
                            begin
                                score_next = {{(qsp_pkg::SCORE_W-qsp_pkg::WAIT_W){1'b0}},
                                              wait_reg};
                                state_next = qsp_pkg::S_CMP;
                            end
                        end
                        qsp_pkg::POL_LARGEST:
                        begin
                            score_next = {{(qsp_pkg::SCORE_W-qsp_pkg::LEN_W){1'b0}},
                                          len_reg};
                            state_next = qsp_pkg::S_CMP;
                        end
                        default:
                        begin
                            // round robin only marks the queue nonempty
                            state_next = qsp_pkg::S_NEXT;
                        end
                    endcase
                end
            end

            qsp_pkg::S_MUL:
            begin
                prod_next  = len_reg * now_reg;
                state_next = qsp_pkg::S_SUB;
            end

            qsp_pkg::S_SUB:
            begin
                num_next   = {2'b00, prod_reg} - {2'b00, asum_reg};
                state_next = qsp_pkg::S_ADD;
            end

            qsp_pkg::S_ADD:
            begin
                num_next   = num_reg + {2'b00, wsum_reg};
                state_next = qsp_pkg::S_ABS;
            end

            qsp_pkg::S_ABS:
            begin
                neg_next     = num_reg[qsp_pkg::NUM_W-1];
                dvd_next     = num_abs[qsp_pkg::MAG_W-1:0];
                rem_next     = '0;
                div_cnt_next = '0;
                state_next   = qsp_pkg::S_DIV;
            end

            qsp_pkg::S_DIV:
            begin
                rem_next     = q_bit ? (rem_shift - wpk_ext) : rem_shift;
                dvd_next     = {dvd_reg[qsp_pkg::MAG_W-2:0], q_bit};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == qsp_pkg::DIV_CNT_W'(qsp_pkg::DIV_STEPS - 1))
                begin
                    state_next = qsp_pkg::S_NEG;
                end
            end

            qsp_pkg::S_NEG:
            begin
                // truncation toward zero: negate the magnitude quotient
                score_next = neg_reg ? (~quot_ext + 1'b1) : quot_ext;
                state_next = qsp_pkg::S_CMP;
            end

            qsp_pkg::S_CMP:
            begin
                if ($signed(score_reg) > $signed(best_score_reg))
                begin
                    best_score_next = score_reg;
                    best_index_next = item_count_reg[IDX_W-1:0];
                    best_found_next = 1'b1;
                end
                state_next = qsp_pkg::S_NEXT;
            end

            qsp_pkg::S_NEXT:
            begin
                if (in_range)
                begin
                    item_count_next = item_count_reg + 1'b1;
                end
                if (!last_reg)
                begin
                    state_next = qsp_pkg::S_IDLE;
                end
                else if (run_policy_reg == qsp_pkg::POL_ROUND_ROBIN)
                begin
                    rr_rem_next = CNT_W'(rr_pointer_reg);
                    state_next  = qsp_pkg::S_MOD;
                end
                else
                begin
                    state_next = qsp_pkg::S_OUT;
                end
            end

            qsp_pkg::S_MOD:
            begin
                srch_k_next = '0;
                if (!rr_valid_reg)
                begin
                    srch_idx_next = '0;
                    state_next    = qsp_pkg::S_SRCH;
                end
                else if (rr_rem_reg >= item_count_reg)
                begin
                    rr_rem_next = rr_rem_reg - item_count_reg;
                end
                else
                begin
                    srch_idx_next = (rr_inc == item_count_reg) ? '0 : rr_inc[IDX_W-1:0];
                    state_next    = qsp_pkg::S_SRCH;
                end
            end

            qsp_pkg::S_SRCH:
            begin
                if (nonempty_reg[srch_idx_reg])
                begin
                    rr_pointer_next = srch_idx_reg;
                    rr_valid_next   = 1'b1;
                    best_index_next = srch_idx_reg;
                    best_found_next = 1'b1;
                    state_next      = qsp_pkg::S_OUT;
                end
                else if (srch_k_inc == item_count_reg)
                begin
                    // no nonempty queue in the run
                    rr_pointer_next = rr_valid_reg ? rr_rem_reg[IDX_W-1:0]
                                                   : cnt_m1[IDX_W-1:0];
                    rr_valid_next   = 1'b1;
                    best_index_next = '0;
                    best_found_next = 1'b0;
                    state_next      = qsp_pkg::S_OUT;
                end
                else
                begin
                    srch_k_next   = srch_k_inc;
                    srch_idx_next = (srch_inc == item_count_reg) ? '0
                                                                 : srch_inc[IDX_W-1:0];
                end
            end

            qsp_pkg::S_OUT:
            begin
                result_valid_next = 1'b1;
                found_next        = best_found_reg;
                chosen_next       = best_found_reg ? idx_ext[qsp_pkg::CHOSEN_W-1:0] : '0;
                nonempty_next     = '0;
                best_score_next   = '1;
                best_index_next   = '0;
                best_found_next   = 1'b0;
                item_count_next   = '0;
                run_policy_next   = qsp_pkg::POL_ROUND_ROBIN;
                state_next        = qsp_pkg::S_IDLE;
            end

            default:
            begin
                state_next = qsp_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= qsp_pkg::S_IDLE;
            policy_reg       <= qsp_pkg::POL_ROUND_ROBIN;
            run_policy_reg   <= qsp_pkg::POL_ROUND_ROBIN;
            rr_pointer_reg   <= '0;
            rr_valid_reg     <= 1'b0;
            nonempty_reg     <= '0;
            best_score_reg   <= '1;
            best_index_reg   <= '0;
            best_found_reg   <= 1'b0;
            item_count_reg   <= '0;
            result_valid_reg <= 1'b0;
            chosen_reg       <= '0;
            found_reg        <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            policy_reg       <= policy_next;
            run_policy_reg   <= run_policy_next;
            rr_pointer_reg   <= rr_pointer_next;
            rr_valid_reg     <= rr_valid_next;
            nonempty_reg     <= nonempty_next;
            best_score_reg   <= best_score_next;
            best_index_reg   <= best_index_next;
            best_found_reg   <= best_found_next;
            item_count_reg   <= item_count_next;
            result_valid_reg <= result_valid_next;
            chosen_reg       <= chosen_next;
            found_reg        <= found_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        now_reg      <= now_next;
        len_reg      <= len_next;
        wait_reg     <= wait_next;
        wpk_reg      <= wpk_next;
        asum_reg     <= asum_next;
        wsum_reg     <= wsum_next;
        last_reg     <= last_next;
        prod_reg     <= prod_next;
        num_reg      <= num_next;
        neg_reg      <= neg_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        div_cnt_reg  <= div_cnt_next;
        score_reg    <= score_next;
        rr_rem_reg   <= rr_rem_next;
        srch_idx_reg <= srch_idx_next;
        srch_k_reg   <= srch_k_next;
    end

    // checks

    // a result strobe only follows the output step of the sequencer
    a_result_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == qsp_pkg::S_OUT))
        else $error("result strobe without output step");

    // no selection means index zero
    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !found) |-> (chosen_queue == '0))
        else $error("chosen_queue nonzero with found low");

    // an accepted transaction always starts evaluation
    a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == qsp_pkg::S_EVAL))
        else $error("accepted transaction not evaluated");

    // divider never runs past its quotient width
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == qsp_pkg::S_DIV)
            |-> (div_cnt_reg < qsp_pkg::DIV_CNT_W'(qsp_pkg::DIV_STEPS)))
        else $error("divider step count overrun");

    // run state is clear whenever a selection has just ended
    a_run_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((item_count_reg == '0) && !best_found_reg
                          && (nonempty_reg == '0)))
        else $error("run state not cleared after result");

endmodule

`default_nettype wire
